[src/pgl_pkg.sv]
package pgl_pkg;
  localparam int MaxUnitsDefault = 64;
  localparam int CoordW = 16;
  localparam int IdW = 16;
  localparam int DistW = 16;
  localparam int LabelW = 6;
  localparam int TotalW = 7;
  localparam logic [DistW-1:0] LinkDistanceReset = 16'd256;

  // squared distance of two points, fits in 34 bits
  localparam int D2W = 34;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic              ok;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } point_t;
endpackage

[src/pgl_dist.sv]
// Two-stage squared-distance compare: |dx|,|dy| registered, then squares summed.
module pgl_dist (
  input  logic                      clk,
  input  logic [pgl_pkg::CoordW-1:0] ax,
  input  logic [pgl_pkg::CoordW-1:0] ay,
  input  logic [pgl_pkg::CoordW-1:0] bx,
  input  logic [pgl_pkg::CoordW-1:0] by,
  input  logic [pgl_pkg::D2W-1:0]    lim,
  output logic                       close
);
  import pgl_pkg::*;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0] adx, ady;
  logic [D2W-1:0] sq_x, sq_y;

  always_comb begin
    dx = $signed({ax[CoordW-1], ax}) - $signed({bx[CoordW-1], bx});
    dy = $signed({ay[CoordW-1], ay}) - $signed({by[CoordW-1], by});
  end

  always_ff @(posedge clk) begin
    adx <= dx[CoordW] ? -dx : dx;
    ady <= dy[CoordW] ? -dy : dy;
  end

  // 17x17 products, zero-extended operands
  always_ff @(posedge clk) begin
    sq_x <= D2W'(adx) * D2W'(adx);
    sq_y <= D2W'(ady) * D2W'(ady);
  end

  assign close = (sq_x + sq_y) < lim;
endmodule

[src/proximity_group_labeler.sv]
// Load: one point beat per cycle while idle; points past MAX_UNITS are dropped.
// Labeling after the last point: each seed candidate is read and checked; each queued
// point is fetched, then the n stored points are scanned through the 3-stage distance
// pipe, which then drains before the next queued point is popped.
// Output: n result beats, each held until out_ready takes it.
// rst is synchronous, active high: clears control, count, link_distance=256.
module proximity_group_labeler #(
  parameter int MAX_UNITS = pgl_pkg::MaxUnitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pgl_pkg::DistW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pgl_pkg::IdW-1:0]       unit_id,
  input  logic                          unit_valid,
  input  logic [pgl_pkg::CoordW-1:0]    pos_x,
  input  logic [pgl_pkg::CoordW-1:0]    pos_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pgl_pkg::IdW-1:0]       point_id,
  output logic [pgl_pkg::LabelW-1:0]    group_label,
  output logic                          ungrouped,
  output logic [pgl_pkg::TotalW-1:0]    group_total,
  output logic                          last_result
);
  import pgl_pkg::*;

  localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CW = $clog2(MAX_UNITS + 1);

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_SEED  = 10'b0000000010,
    S_SEEDW = 10'b0000000100,
    S_POP   = 10'b0000001000,
    S_POPW  = 10'b0000010000,
    S_FETCH = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_DRAIN = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_OUTW  = 10'b1000000000
  } state_t;

  state_t state;
  logic [DistW-1:0] link_distance;
  logic [D2W-1:0] lim;
  logic [CW-1:0] count;
  logic [TotalW-1:0] groups;
  logic [AW-1:0] seed;        // next seed candidate
  logic [CW-1:0] head, tail;
  logic [CW-1:0] scan_idx;    // issue index of scan
  logic [AW-1:0] cur;
  logic [MAX_UNITS-1:0] taken;

  // point memory (one write, one registered read), labels and queue
  point_t pmem [MAX_UNITS];
  logic [LabelW-1:0] lmem [MAX_UNITS];
  logic [AW-1:0] qmem [MAX_UNITS];
  point_t prd;
  logic [LabelW-1:0] lrd;
  logic [AW-1:0] qrd;
  logic [AW-1:0] raddr;
  logic p_we, l_we, q_we;
  logic [AW-1:0] p_wa, l_wa, q_wa;
  point_t p_wd;
  logic [AW-1:0] q_wd;
  logic [LabelW-1:0] l_wd;

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_wa] <= p_wd;
    if (l_we) lmem[l_wa] <= l_wd;
    if (q_we) qmem[q_wa] <= q_wd;
    prd <= pmem[raddr];
    lrd <= lmem[raddr];
    qrd <= qmem[head[AW-1:0]];
  end

  // coordinates of the point being expanded, held for the scan
  logic [CoordW-1:0] cx, cy;
  // scan pipeline tags: index and candidacy, 3 stages (mem read, dist x2)
  logic [AW-1:0] t_idx [3];
  logic          t_v   [3];
  logic close;

  pgl_dist u_dist (
    .clk(clk), .ax(cx), .ay(cy), .bx(prd.x), .by(prd.y), .lim(lim), .close(close)
  );

  assign lim = D2W'(link_distance) * D2W'(link_distance);
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_LOAD);

  // output index
  logic [CW-1:0] out_idx;

  // POP reads the queue head, POPW reads that point, FETCH sees its coordinates
  always_comb begin
    raddr = seed;
    unique case (state)
      S_SCAN:           raddr = scan_idx[AW-1:0];
      S_OUT, S_OUTW:    raddr = out_idx[AW-1:0];
      S_POP, S_POPW:    raddr = qrd;
      default:          raddr = seed;
    endcase
  end

  logic accept_in, hit;
  assign accept_in = in_valid && in_ready;
  assign hit = t_v[2] && close && !taken[t_idx[2]];

  always_comb begin
    p_we = accept_in && (count < CW'(MAX_UNITS));
    p_wa = count[AW-1:0];
    p_wd = '{id: unit_id, ok: unit_valid, x: pos_x, y: pos_y};
    l_we = 1'b0; l_wa = seed; l_wd = groups[LabelW-1:0];
    q_we = 1'b0; q_wa = tail[AW-1:0]; q_wd = seed;
    if (state == S_SEEDW && prd.ok && !taken[seed]) begin
      // new group: seed goes to the queue front
      l_we = 1'b1; q_we = 1'b1; q_wa = '0;
    end else if (state == S_SCAN || state == S_DRAIN) begin
      l_we = hit; l_wa = t_idx[2];
      q_we = hit; q_wd = t_idx[2];
    end
  end

  logic ovalid;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; link_distance <= LinkDistanceReset; count <= '0;
      groups <= '0; ovalid <= 1'b0; taken <= '0; seed <= '0;
      head <= '0; tail <= '0; scan_idx <= '0; out_idx <= '0;
      for (int k = 0; k < 3; k++) t_v[k] <= 1'b0;
    end else begin
      if (cfg_valid) link_distance <= cfg_data;
      t_v[0] <= (state == S_SCAN) && (scan_idx < count);
      t_idx[0] <= scan_idx[AW-1:0];
      t_v[1] <= t_v[0] && prd.ok; t_idx[1] <= t_idx[0];
      t_v[2] <= t_v[1]; t_idx[2] <= t_idx[1];
      if (hit && (state == S_SCAN || state == S_DRAIN)) begin
        taken[t_idx[2]] <= 1'b1;
        tail <= tail + 1'b1;
      end
      if (state == S_OUTW) ovalid <= 1'b1;
      else if (out_ready) ovalid <= 1'b0;
      unique case (state)
        S_LOAD: if (accept_in) begin
          if (count < CW'(MAX_UNITS)) count <= count + 1'b1;
          if (last_point) begin
            state <= S_SEED; seed <= '0; groups <= '0; taken <= '0;
          end
        end
        S_SEED: state <= S_SEEDW;  // read seed point
        S_SEEDW: begin
          if (CW'(seed) >= count) begin
            state <= S_OUT; out_idx <= '0;
          end else if (prd.ok && !taken[seed]) begin
            taken[seed] <= 1'b1; head <= '0; tail <= CW'(1);
            state <= S_POP;
          end else begin
            seed <= seed + 1'b1; state <= S_SEED;
            if (CW'(seed) + 1'b1 >= count) begin
              state <= S_OUT; out_idx <= '0;
            end
          end
        end
        S_POP: begin
          if (head == tail) begin
            groups <= groups + 1'b1;
            if (CW'(seed) + 1'b1 >= count) begin
              state <= S_OUT; out_idx <= '0;
            end else begin
              seed <= seed + 1'b1; state <= S_SEED;
            end
          end else state <= S_POPW;  // qrd valid next cycle
        end
        S_POPW: begin
          cur <= qrd;
          state <= S_FETCH;
        end
        S_FETCH: begin
          cx <= prd.x; cy <= prd.y;
          state <= S_SCAN; scan_idx <= '0;
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx >= count) state <= S_DRAIN;
        end
        S_DRAIN: if (!t_v[0] && !t_v[1] && !t_v[2]) begin
          head <= head + 1'b1; state <= S_POP;
        end
        S_OUT: if (!ovalid || out_ready) state <= S_OUTW;
        S_OUTW: begin
          point_id <= prd.id;
          ungrouped <= !prd.ok;
          group_label <= prd.ok ? lrd : '0;
          group_total <= groups;
          last_result <= (out_idx + 1'b1 == count);
          out_idx <= out_idx + 1'b1;
          if (out_idx + 1'b1 == count) begin
            state <= S_LOAD; count <= '0;
          end else state <= S_OUT;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign out_valid = ovalid;

  // a hit in the scan never hits the point being expanded
  assert property (@(posedge clk) disable iff (rst)
    hit |-> (t_idx[2] != cur)) else $error("self link");
  assert property (@(posedge clk) disable iff (rst)
    (tail <= CW'(MAX_UNITS))) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(point_id)))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ready) else $error("load during run");
endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pgl_pkg::*;

  localparam int Units = MaxUnitsDefault;

  // one result beat as predicted
  typedef struct {
    logic [IdW-1:0]    id;
    logic [LabelW-1:0] label;
    logic              lone;
    logic [TotalW-1:0] total;
    logic              tail;
  } label_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DistW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IdW-1:0] unit_id = '0;
  logic unit_valid = 1'b0;
  logic [CoordW-1:0] pos_x = '0;
  logic [CoordW-1:0] pos_y = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IdW-1:0] point_id;
  logic [LabelW-1:0] group_label;
  logic ungrouped;
  logic [TotalW-1:0] group_total;
  logic last_result;

  proximity_group_labeler dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .unit_id(unit_id), .unit_valid(unit_valid), .pos_x(pos_x), .pos_y(pos_y),
    .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_id(point_id), .group_label(group_label), .ungrouped(ungrouped),
    .group_total(group_total), .last_result(last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: our own copy of the point store and the threshold
  logic [DistW-1:0] link_dist;
  point_t           held_pts[Units];
  int               held_count;
  label_beat_t      expected_labels[$];

  int mismatches = 0;
  int beats_seen = 0;
  int loads_sent = 0;
  bit quiet = 1'b0;  // no idling on either side while set

  // union-by-BFS labeling of the stored load, queued in load order
  task automatic predict_groups();
    bit taken[Units];
    int walk[$];
    int groups;
    int cur;
    logic [LabelW-1:0] lab[Units];
    longint dx, dy, d2, lim;
    label_beat_t b;
    groups = 0;
    lim = longint'(link_dist) * longint'(link_dist);
    for (int i = 0; i < held_count; i++) begin
      taken[i] = 1'b0;
      lab[i] = '0;
    end
    for (int i = 0; i < held_count; i++) begin
      if (!held_pts[i].ok || taken[i]) continue;
      taken[i] = 1'b1;
      lab[i] = groups[LabelW-1:0];
      walk = {i};
      while (walk.size() > 0) begin
        cur = walk.pop_front();
        for (int j = 0; j < held_count; j++) begin
          if (!held_pts[j].ok || taken[j]) continue;
          dx = longint'($signed(held_pts[cur].x)) - longint'($signed(held_pts[j].x));
          dy = longint'($signed(held_pts[cur].y)) - longint'($signed(held_pts[j].y));
          d2 = dx * dx + dy * dy;
          if (d2 < lim) begin
            taken[j] = 1'b1;
            lab[j] = groups[LabelW-1:0];
            walk = {walk, j};
          end
        end
      end
      groups++;
    end
    for (int i = 0; i < held_count; i++) begin
      b.id = held_pts[i].id;
      b.label = held_pts[i].ok ? lab[i] : '0;
      b.lone = !held_pts[i].ok;
      b.total = groups[TotalW-1:0];
      b.tail = (i == held_count - 1);
      expected_labels = {expected_labels, b};
    end
    held_count = 0;
  endtask

  // random idle: about 34 in 100 unless in a quiet stretch
  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 34);
  endfunction

  // send one point beat; valid stays up until accepted, returns at that edge
  task automatic send_point(input logic [IdW-1:0] id, input logic ok,
                            input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic lastp);
    point_t p;
    @(negedge clk);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    unit_id    <= id;
    unit_valid <= ok;
    pos_x      <= x;
    pos_y      <= y;
    last_point <= lastp;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: mirror into the predictor
    p.id = id; p.ok = ok; p.x = x; p.y = y;
    if (held_count < Units) begin
      held_pts[held_count] = p;
      held_count++;
    end
    if (lastp) begin
      predict_groups();
      loads_sent++;
    end
  endtask

  // drop the input, wait until every predicted result is checked, idle a bit
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_labels.size() > 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_link_distance(input logic [DistW-1:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    link_dist = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a load of n points clustered around a center with given spread
  task automatic send_cluster_load(input int n, input int spread, input int pinvalid);
    logic [IdW-1:0] base;
    int cx, cy;
    base = IdW'($urandom_range(16'hFF00));
    cx = $urandom_range(60000) - 30000;
    cy = $urandom_range(60000) - 30000;
    for (int i = 0; i < n; i++) begin
      send_point(base + i[IdW-1:0], $urandom_range(99) >= pinvalid,
                 16'(cx + $urandom_range(2 * spread) - spread),
                 16'(cy + $urandom_range(2 * spread) - spread), i == n - 1);
    end
  endtask

  // result checker: samples at rising edge
  always @(posedge clk) begin
    label_beat_t e;
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (expected_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat id=%0d", point_id);
      end else begin
        e = expected_labels.pop_front();
        if (point_id !== e.id || group_label !== e.label || ungrouped !== e.lone ||
            group_total !== e.total || last_result !== e.tail) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat mismatch: exp id=%0d lab=%0d ung=%0b tot=%0d last=%0b",
                     e.id, e.label, e.lone, e.total, e.tail);
            $display("               got id=%0d lab=%0d ung=%0b tot=%0d last=%0b",
                     point_id, group_label, ungrouped, group_total, last_result);
          end
        end
      end
    end
  end

  // output backpressure
  always @(negedge clk) out_ready <= !idle_now();

  // extremes of every field, lone and invalid points, all-invalid load
  task automatic test_directed();
    send_point(16'h0000, 1'b1, 16'h8000, 16'h8000, 1'b0);
    send_point(16'hFFFF, 1'b1, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h1234, 1'b0, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0010, 1'b1, 16'h0000, 16'h00FF, 1'b0);  // just inside 256
    send_point(16'h0011, 1'b1, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0012, 1'b1, 16'h0100, 16'h0000, 1'b1);  // exactly 256: no link
    // single-point load
    send_point(16'h5555, 1'b1, 16'hAAAA, 16'h5555, 1'b1);
    // no valid points
    send_point(16'h0001, 1'b0, 16'hFFFF, 16'h0001, 1'b0);
    send_point(16'h0001, 1'b0, 16'h8000, 16'h7FFF, 1'b1);  // repeated id
    // ids out of order, points spaced exactly 256 apart, so none link
    send_point(16'h0300, 1'b1, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0200, 1'b1, 16'h0200, 16'h0000, 1'b0);
    send_point(16'h0100, 1'b1, 16'h0100, 16'h0000, 1'b1);
  endtask

  // zero threshold: every valid point alone; max threshold: a wide cluster, then two opposite corners that stay apart
  task automatic test_threshold_extremes();
    write_link_distance(16'd0);
    send_cluster_load(8, 2, 20);
    write_link_distance(16'hFFFF);
    send_cluster_load(10, 30000, 20);
    send_point(16'h0A00, 1'b1, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h0A01, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1);
  endtask

  // full store plus dropped points, one of them carrying last_point;
  // sent with no idling on either side
  task automatic test_store_full();
    write_link_distance(16'd1000);
    quiet = 1'b1;
    for (int i = 0; i < Units + 3; i++)
      send_point(16'(i), $urandom_range(9) != 0, 16'($urandom),
                 16'($urandom), i == Units + 2);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_loads();
    int n;
    int sent;
    sent = 0;
    while (sent < 55) begin
      if ($urandom_range(4) == 0) write_link_distance(16'($urandom_range(4000)));
      if ($urandom_range(5) == 0) begin
        drain();  // sender pauses until every result is back
      end
      quiet = (sent >= 15 && sent < 35);
      n = $urandom_range(12, 1);
      if ($urandom_range(9) == 0) begin
        // raw noise load
        for (int i = 0; i < n; i++)
          send_point(16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                     i == n - 1);
      end else begin
        send_cluster_load(n, $urandom_range(3000), 15);
      end
      sent += n;
    end
    quiet = 1'b0;
  endtask

  initial begin
    link_dist = LinkDistanceReset;
    held_count = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_threshold_extremes();
    test_store_full();
    test_random_loads();
    write_link_distance(LinkDistanceReset);
    send_cluster_load(5, 300, 10);
    drain();
    $display("covered %0d loads, %0d result beats checked, distances 0 to 65535",
             loads_sent, beats_seen);
    if (mismatches == 0 && expected_labels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[proximity_group_labeler.f]
src/pgl_pkg.sv
src/pgl_dist.sv
src/proximity_group_labeler.sv
dv/tb_top.sv
